/* hw/rtl/tsnp_pkg.sv */
// ----------------------------------------------------------------------------
// tsnp_pkg
// Shared types and constants for the transport stream new-PID detector.
// ----------------------------------------------------------------------------
package tsnp_pkg;

  // Width of a packet identifier.
  localparam int unsigned PID_W = 13;

  // Width of the byte position counter inside a stride.
  localparam int unsigned POS_W = 8;

  // Sync byte that opens every transport stream packet.
  localparam logic [7:0] SYNC_BYTE = 8'h47;

  // Lookup request from the packet scanner to the seen map.
  typedef struct packed {
    logic             valid;
    logic [PID_W-1:0] pid;
  } tsnp_lookup_t;

  // Outcome of a seen-map lookup, formed in the compare stage from the read bit.
  typedef struct packed {
    logic             pending;  // a lookup is in the compare stage
    logic             is_new;   // the PID was not yet marked
    logic [PID_W-1:0] pid;
  } tsnp_result_t;

endpackage

/* hw/rtl/tsnp_scanner.sv */
// ----------------------------------------------------------------------------
// tsnp_scanner
// Tracks the byte position inside a packet stride, checks the sync byte and
// assembles the PID from the two bytes after it.
// ----------------------------------------------------------------------------
module tsnp_scanner
  import tsnp_pkg::*;
#(
  parameter int unsigned PACKET_BYTES = 188
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         accept_i,
  input  logic [7:0]   ts_byte_i,
  input  logic         buffer_last_i,
  output tsnp_lookup_t lookup_o
);

  localparam logic [POS_W-1:0] StrideEndSync = POS_W'(PACKET_BYTES - 1);
  localparam logic [POS_W-1:0] StrideEndSkip = POS_W'(PACKET_BYTES);
  localparam logic [POS_W-1:0] PosStart      = '0;
  localparam logic [POS_W-1:0] PosPidHigh    = POS_W'(1);
  localparam logic [POS_W-1:0] PosPidLow     = POS_W'(2);

  logic [POS_W-1:0] pos_q, pos_d;
  logic             skip_q, skip_d;
  logic [4:0]       pid_high_q, pid_high_d;
  logic             skip_now;
  logic [POS_W-1:0] stride_end;

  // The skip flag is decided by the byte at the packet start.
  assign skip_now   = (pos_q == PosStart) ? (ts_byte_i != SYNC_BYTE) : skip_q;
  assign stride_end = skip_now ? StrideEndSkip : StrideEndSync;

  // The second PID byte completes the identifier and starts a lookup.
  assign lookup_o.valid = accept_i && (pos_q == PosPidLow) && !skip_q;
  assign lookup_o.pid   = {pid_high_q, ts_byte_i};

  // Next position, skip flag and upper PID bits.
  always_comb begin
    pos_d      = pos_q;
    skip_d     = skip_q;
    pid_high_d = pid_high_q;
    if (accept_i) begin
      if ((pos_q == PosPidHigh) && !skip_q) begin
        pid_high_d = ts_byte_i[4:0];
      end
      if (buffer_last_i || (pos_q >= stride_end)) begin
        pos_d  = PosStart;
        skip_d = 1'b0;
      end else begin
        pos_d  = pos_q + POS_W'(1);
        skip_d = skip_now;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      skip_q     <= 1'b0;
      pid_high_q <= '0;
    end else begin
      pos_q      <= pos_d;
      skip_q     <= skip_d;
      pid_high_q <= pid_high_d;
    end
  end

endmodule

/* hw/rtl/tsnp_seen_map.sv */
// ----------------------------------------------------------------------------
// tsnp_seen_map
// One-bit-per-PID memory. A lookup reads the entry, the next cycle compares
// it and writes the mark back. A clearing pass runs after reset.
// ----------------------------------------------------------------------------
module tsnp_seen_map
  import tsnp_pkg::*;
#(
  parameter int unsigned PID_COUNT = 8192
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  tsnp_lookup_t lookup_i,
  output tsnp_result_t result_o,
  output logic         clearing_o
);

  localparam int unsigned AW = $clog2(PID_COUNT);
  localparam logic [AW-1:0] LastAddr = AW'(PID_COUNT - 1);
  localparam logic [PID_W:0] PidLimit = (PID_W + 1)'(PID_COUNT);

  logic             mem_q [PID_COUNT];
  logic             rd_bit_q;
  logic             s2_valid_q;
  logic             s2_in_range_q;
  logic [PID_W-1:0] s2_pid_q;
  logic             clr_busy_q;
  logic [AW-1:0]    clr_addr_q;
  logic             in_range;
  logic             mark_we;
  logic             mem_we;
  logic [AW-1:0]    mem_wa;
  logic             mem_wd;

  // PIDs beyond the map have no entry and are never reported.
  assign in_range = ({1'b0, lookup_i.pid} < PidLimit);

  // Mark a PID that the compare stage finds unseen.
  assign mark_we = s2_valid_q && s2_in_range_q && !rd_bit_q;

  // Writes come from the clearing pass or from the mark write-back. Lookups
  // are at least three transactions apart, so a read never meets a pending
  // write to the same entry.
  assign mem_we = clr_busy_q || mark_we;
  assign mem_wa = clr_busy_q ? clr_addr_q : s2_pid_q[AW-1:0];
  assign mem_wd = !clr_busy_q;

  // Memory array: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (lookup_i.valid) begin
      rd_bit_q <= mem_q[lookup_i.pid[AW-1:0]];
    end
  end

  // Compare stage payload.
  always_ff @(posedge clk_i) begin
    if (lookup_i.valid) begin
      s2_pid_q      <= lookup_i.pid;
      s2_in_range_q <= in_range;
    end
  end

  // Compare stage valid and clearing pass control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      s2_valid_q <= lookup_i.valid;
      if (clr_busy_q) begin
        clr_addr_q <= clr_addr_q + AW'(1);
        if (clr_addr_q == LastAddr) begin
          clr_busy_q <= 1'b0;
        end
      end
    end
  end

  assign result_o.pending = s2_valid_q;
  assign result_o.is_new  = mark_we;
  assign result_o.pid     = s2_pid_q;
  assign clearing_o       = clr_busy_q;

endmodule

/* hw/rtl/tsnp_out_buf.sv */
// ----------------------------------------------------------------------------
// tsnp_out_buf
// Two-entry result buffer that parts the output channel from the lookup
// pipeline.
// ----------------------------------------------------------------------------
module tsnp_out_buf
  import tsnp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [PID_W-1:0] push_pid_i,
  output logic [1:0]       count_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [PID_W-1:0] out_pid_o
);

  logic [1:0]       count_q, count_d;
  logic [PID_W-1:0] head_q, head_d;
  logic [PID_W-1:0] tail_q, tail_d;
  logic             pop;

  assign pop = (count_q != 2'd0) && !out_stall_i;

  // Shift-style update: the head always holds the oldest result.
  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (pop) begin
      head_d = tail_q;
    end
    if (push_i) begin
      if ((count_q == 2'd0) || (pop && (count_q == 2'd1))) begin
        head_d = push_pid_i;
      end else begin
        tail_d = push_pid_i;
      end
    end
    count_d = count_q + 2'(push_i) - 2'(pop);
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign count_o     = count_q;
  assign out_valid_o = (count_q != 2'd0);
  assign out_pid_o   = head_q;

endmodule

/* hw/rtl/ts_new_pid_detector_unit.sv */
// ----------------------------------------------------------------------------
// ts_new_pid_detector_unit
// Scans a transport stream byte by byte and reports each in-range PID the
// first time it appears after reset in a packet that opens with SYNC_BYTE.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                      Payload
//   ts        in         ts_valid_i / ts_stall_o        ts_byte_i, buffer_last_i
//   new_pid   out        new_pid_valid_o / new_pid_stall_i  new_pid_o
//
// One byte is taken every cycle unless ts_stall_o is high. A new PID moves
// from its second PID byte through the registered seen-map read and the
// compare-and-mark stage into the output buffer. After reset the map is
// cleared one entry per cycle, all PID_COUNT entries, with ts_stall_o high.
// The input stalls when the two-entry output buffer could not take a result.
module ts_new_pid_detector_unit
  import tsnp_pkg::*;
#(
  parameter int unsigned PACKET_BYTES = 188,
  parameter int unsigned PID_COUNT    = 8192
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             ts_valid_i,
  output logic             ts_stall_o,
  input  logic [7:0]       ts_byte_i,
  input  logic             buffer_last_i,
  output logic             new_pid_valid_o,
  input  logic             new_pid_stall_i,
  output logic [PID_W-1:0] new_pid_o
);

  tsnp_lookup_t lookup;
  tsnp_result_t result;
  logic         clearing;
  logic [1:0]   buf_count;
  logic         ts_accept;

  // Hold off input while the map clears or while a pending result could
  // find the buffer full.
  assign ts_stall_o = clearing || (buf_count == 2'd2) ||
                      ((buf_count == 2'd1) && result.pending);
  assign ts_accept  = ts_valid_i && !ts_stall_o;

  tsnp_scanner #(
    .PACKET_BYTES(PACKET_BYTES)
  ) u_scanner (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (ts_accept),
    .ts_byte_i    (ts_byte_i),
    .buffer_last_i(buffer_last_i),
    .lookup_o     (lookup)
  );

  tsnp_seen_map #(
    .PID_COUNT(PID_COUNT)
  ) u_seen_map (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .lookup_i  (lookup),
    .result_o  (result),
    .clearing_o(clearing)
  );

  tsnp_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (result.is_new),
    .push_pid_i (result.pid),
    .count_o    (buf_count),
    .out_valid_o(new_pid_valid_o),
    .out_stall_i(new_pid_stall_i),
    .out_pid_o  (new_pid_o)
  );

endmodule

/* hw/rtl/tsnp_checker.sv */
// ----------------------------------------------------------------------------
// tsnp_checker
// Port-level checks for the new-PID detector, bound to the top level.
// ----------------------------------------------------------------------------
module tsnp_checker
  import tsnp_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             ts_valid_i,
  input logic             ts_stall_o,
  input logic             new_pid_valid_o,
  input logic             new_pid_stall_i,
  input logic [PID_W-1:0] new_pid_o
);

  logic in_xact;
  logic out_xact;

  assign in_xact  = ts_valid_i && !ts_stall_o;
  assign out_xact = new_pid_valid_o && !new_pid_stall_i;

  // A stalled result stays offered.
  a_out_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    new_pid_valid_o && new_pid_stall_i |=> new_pid_valid_o)
    else $error("new_pid_valid_o dropped while stalled");

  // Each PID is reported once, so two back-to-back transactions differ.
  a_no_repeat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xact |=> !(out_xact && (new_pid_o == $past(new_pid_o))))
    else $error("same PID reported twice in a row");

  // A result appears on an empty output only after an input transaction.
  a_result_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(new_pid_valid_o) |-> $past(in_xact, 2))
    else $error("result without a matching input transaction");

endmodule

bind ts_new_pid_detector_unit tsnp_checker u_tsnp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .ts_valid_i     (ts_valid_i),
  .ts_stall_o     (ts_stall_o),
  .new_pid_valid_o(new_pid_valid_o),
  .new_pid_stall_i(new_pid_stall_i),
  .new_pid_o      (new_pid_o)
);
